### design/quoted_command_line_lexer_top_defines.svh
// ----------------------------------------------------------------------------
// Quoted command line lexer assertion macros
// Shared property wrappers for the checker; clocked on clk and disabled
// while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef QUOTED_COMMAND_LINE_LEXER_TOP_DEFINES_SVH
`define QUOTED_COMMAND_LINE_LEXER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QCLL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QCLL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/qcll_pkg.sv
// ----------------------------------------------------------------------------
// Quoted command line lexer package
// Shared constants, result codes and the record passed from front to back.
// ----------------------------------------------------------------------------
package qcll_pkg;

	localparam int MAX_TOKENS = 256;
	localparam int CNT_W      = $clog2(MAX_TOKENS + 1);
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// Result kinds.
	localparam logic [1:0] KIND_CHAR   = 2'd0;
	localparam logic [1:0] KIND_END    = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	// Token types.
	localparam logic [2:0] TY_ARG     = 3'd0;
	localparam logic [2:0] TY_CMD     = 3'd1;
	localparam logic [2:0] TY_PIPE    = 3'd2;
	localparam logic [2:0] TY_OUT     = 3'd3;
	localparam logic [2:0] TY_APPEND  = 3'd4;
	localparam logic [2:0] TY_IN      = 3'd5;
	localparam logic [2:0] TY_HEREDOC = 3'd6;

	// Line status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_UNCLOSED = 2'd1;
	localparam logic [1:0] ST_NO_ARG   = 2'd2;

	// Special bytes.
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_LT     = 8'h3C;

	localparam logic [7:0] IDX_MAX = 8'hFF;

	// Everything one input byte produces, up to three results.
	typedef struct packed {
		logic       has_char;
		logic [7:0] ch;
		logic [7:0] char_idx;
		logic       has_end;
		logic [2:0] end_type;
		logic [7:0] end_idx;
		logic       has_status;
		logic [1:0] status;
		logic [7:0] status_idx;
	} qcll_rec_t;

	typedef struct packed {
		logic empty;
		logic full;
	} qcll_qstat_t;

	function automatic logic [7:0] sat_index(input logic [CNT_W-1:0] count);
		if (int'(count) > int'(IDX_MAX)) begin
			return IDX_MAX;
		end
		return 8'(count);
	endfunction

endpackage

### design/qcll_front.sv
// ----------------------------------------------------------------------------
// Quoted command line lexer front end
// Tracks token and quote state per byte and classifies each byte into a
// record of the character, token end and line status results it causes.
// ----------------------------------------------------------------------------
module qcll_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        char_in,
	input  logic              end_of_line,
	output logic              rec_valid,
	output qcll_pkg::qcll_rec_t rec
);
	import qcll_pkg::*;

	logic             tok_q, inq_q, dbl_q, opp_q, err_q;
	logic [15:0]      head_q;
	logic [1:0]       len_q;
	logic [CNT_W-1:0] count_q;
	logic [2:0]       prev_q;

	logic             start, tok_a, tok_b, is_quote, is_dq;
	logic             space_end, quote_ev, char_ev, eol_end, has_end, is_op;
	logic             inq_b, dbl_b, opp_b, err_b;
	logic [15:0]      head_a, head_b;
	logic [1:0]       len_a, len_b;
	logic [CNT_W-1:0] count_b;
	logic [2:0]       prev_b, end_type;
	logic [1:0]       line_status;

	always_comb begin
		start    = !tok_q && (char_in != CH_SPACE);
		tok_a    = tok_q || start;
		head_a   = start ? 16'd0 : head_q;
		len_a    = start ? 2'd0 : len_q;
		is_quote = char_in inside {CH_SQUOTE, CH_DQUOTE};
		is_dq    = (char_in == CH_DQUOTE);

		space_end = tok_a && !inq_q && (char_in == CH_SPACE);
		quote_ev  = tok_a && !space_end && is_quote;
		char_ev   = tok_a && !space_end && !is_quote;

		inq_b = inq_q;
		dbl_b = dbl_q;
		if (quote_ev) begin
			if (!inq_q) begin
				inq_b = 1'b1;
				dbl_b = is_dq;
			end else if (is_dq == dbl_q) begin
				inq_b = 1'b0;
			end
		end

		// Only the first two kept bytes matter for operator matching.
		head_b = head_a;
		len_b  = len_a;
		if (char_ev) begin
			if (len_a == 2'd0) begin
				head_b[7:0] = char_in;
			end else if (len_a == 2'd1) begin
				head_b[15:8] = char_in;
			end
			if (len_a != 2'd3) begin
				len_b = len_a + 2'd1;
			end
		end

		tok_b   = tok_a && !space_end;
		eol_end = end_of_line && tok_b && !inq_b;
		has_end = space_end || eol_end;

		end_type = ((count_q == '0) || (prev_q == TY_PIPE)) ? TY_CMD : TY_ARG;
		if (len_b == 2'd1) begin
			case (head_b[7:0])
				CH_PIPE: end_type = TY_PIPE;
				CH_GT:   end_type = TY_OUT;
				CH_LT:   end_type = TY_IN;
				default: ;
			endcase
		end else if (len_b == 2'd2) begin
			if (head_b[7:0] == CH_GT && head_b[15:8] == CH_GT) begin
				end_type = TY_APPEND;
			end else if (head_b[7:0] == CH_LT && head_b[15:8] == CH_LT) begin
				end_type = TY_HEREDOC;
			end
		end
		is_op = end_type inside {TY_PIPE, TY_OUT, TY_APPEND, TY_IN, TY_HEREDOC};

		err_b   = err_q;
		opp_b   = opp_q;
		prev_b  = prev_q;
		count_b = count_q;
		if (has_end) begin
			err_b  = err_q || (opp_q && is_op);
			opp_b  = is_op;
			prev_b = end_type;
			if (count_q != CNT_W'(MAX_TOKENS)) begin
				count_b = count_q + CNT_W'(1);
			end
		end

		if (inq_b) begin
			line_status = ST_UNCLOSED;
		end else if (err_b || opp_b) begin
			line_status = ST_NO_ARG;
		end else begin
			line_status = ST_OK;
		end

		rec.has_char   = char_ev;
		rec.ch         = char_in;
		rec.char_idx   = sat_index(count_q);
		rec.has_end    = has_end;
		rec.end_type   = end_type;
		rec.end_idx    = sat_index(count_q);
		rec.has_status = end_of_line;
		rec.status     = line_status;
		rec.status_idx = sat_index(count_b);

		rec_valid = accept && (char_ev || has_end || end_of_line);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q   <= 1'b0;
			inq_q   <= 1'b0;
			dbl_q   <= 1'b0;
			head_q  <= 16'd0;
			len_q   <= 2'd0;
			count_q <= '0;
			prev_q  <= TY_ARG;
			opp_q   <= 1'b0;
			err_q   <= 1'b0;
		end else if (accept) begin
			if (end_of_line) begin
				tok_q   <= 1'b0;
				inq_q   <= 1'b0;
				dbl_q   <= 1'b0;
				head_q  <= 16'd0;
				len_q   <= 2'd0;
				count_q <= '0;
				prev_q  <= TY_ARG;
				opp_q   <= 1'b0;
				err_q   <= 1'b0;
			end else begin
				tok_q   <= tok_b;
				inq_q   <= inq_b;
				dbl_q   <= dbl_b;
				head_q  <= head_b;
				len_q   <= len_b;
				count_q <= count_b;
				prev_q  <= prev_b;
				opp_q   <= opp_b;
				err_q   <= err_b;
			end
		end
	end

endmodule

### design/qcll_fifo.sv
// ----------------------------------------------------------------------------
// Quoted command line lexer record queue
// Short first-in first-out queue of per-byte records between front and back.
// ----------------------------------------------------------------------------
module qcll_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  qcll_pkg::qcll_rec_t   wr_data,
	input  logic                  rd_en,
	output qcll_pkg::qcll_rec_t   rd_data,
	output qcll_pkg::qcll_qstat_t qstat
);
	import qcll_pkg::*;

	qcll_rec_t          mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CW-1:0] cnt_q;

	assign rd_data     = mem_q[rd_ptr_q];
	assign qstat.empty = (cnt_q == '0);
	assign qstat.full  = (cnt_q == FIFO_CW'(FIFO_DEPTH));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + FIFO_AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + FIFO_AW'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + FIFO_CW'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - FIFO_CW'(1);
			end
		end
	end

endmodule

### design/qcll_back.sv
// ----------------------------------------------------------------------------
// Quoted command line lexer back end
// Unpacks each queued record into its results, one per cycle while the
// output is free or popped, through an output register.
// ----------------------------------------------------------------------------
module qcll_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  qcll_pkg::qcll_rec_t   head,
	input  qcll_pkg::qcll_qstat_t qstat,
	output logic                  fifo_pop,
	output logic                  empty,
	input  logic                  pop,
	output logic [1:0]            kind,
	output logic [7:0]            char_out,
	output logic [2:0]            token_type,
	output logic [7:0]            token_index,
	output logic [1:0]            status,
	output logic                  last
);
	import qcll_pkg::*;

	// Bit 0 character, bit 1 token end, bit 2 line status.
	logic [2:0] done_q;
	logic [2:0] rem, sel, rem_after;
	logic       load, sel_last;
	logic       out_valid_q;
	logic [1:0] kind_q, status_q;
	logic [7:0] char_q, index_q;
	logic [2:0] type_q;
	logic       last_q;

	logic [1:0] kind_d, status_d;
	logic [7:0] char_d, index_d;
	logic [2:0] type_d;

	always_comb begin
		rem  = {head.has_status, head.has_end, head.has_char} & ~done_q;
		load = (!out_valid_q || pop) && !qstat.empty;
		if (rem[0]) begin
			sel      = 3'b001;
			kind_d   = KIND_CHAR;
			char_d   = head.ch;
			type_d   = TY_ARG;
			index_d  = head.char_idx;
			status_d = ST_OK;
		end else if (rem[1]) begin
			sel      = 3'b010;
			kind_d   = KIND_END;
			char_d   = 8'd0;
			type_d   = head.end_type;
			index_d  = head.end_idx;
			status_d = ST_OK;
		end else begin
			sel      = 3'b100;
			kind_d   = KIND_STATUS;
			char_d   = 8'd0;
			type_d   = TY_ARG;
			index_d  = head.status_idx;
			status_d = head.status;
		end
		rem_after = rem & ~sel;
		sel_last  = (rem_after == 3'b000);
		fifo_pop  = load && sel_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= 3'b000;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				done_q      <= sel_last ? 3'b000 : (done_q | sel);
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q   <= kind_d;
			char_q   <= char_d;
			type_q   <= type_d;
			index_q  <= index_d;
			status_q <= status_d;
			last_q   <= sel_last;
		end
	end

	assign empty       = !out_valid_q;
	assign kind        = kind_q;
	assign char_out    = char_q;
	assign token_type  = type_q;
	assign token_index = index_q;
	assign status      = status_q;
	assign last        = last_q;

endmodule

### design/quoted_command_line_lexer_top.sv
// ----------------------------------------------------------------------------
// Quoted command line lexer top level
// Input channel: push/full carries one command-line byte (char_in) and the
// end_of_line flag. Output channel: empty/pop carries results: kept token
// characters, token ends with their type and index, and a line status.
// Each input byte yields zero to three results; last marks the final one.
// A front end updates quote and token state for one byte per cycle while
// the queue is not full and writes a record for each byte with results into
// a four-entry queue; the back end drains one result per cycle while pop
// takes them, into an output register. A result passes from its accepted
// byte through the queue and then the output register to the output ports.
// Throughput: one byte per cycle while each byte yields at most one result
// and pop stays high; a byte with several results holds its record at the
// queue head until the single output register has passed each of them.
// Reset clears all line state, the queue and the output's valid flag.
// When pop stays low the result holds, the queue fills and full rises;
// the block then takes no new byte until space frees up.
// ----------------------------------------------------------------------------
module quoted_command_line_lexer_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] char_in,
	input  logic       end_of_line,
	output logic       empty,
	input  logic       pop,
	output logic [1:0] kind,
	output logic [7:0] char_out,
	output logic [2:0] token_type,
	output logic [7:0] token_index,
	output logic [1:0] status,
	output logic       last
);
	import qcll_pkg::*;

	qcll_qstat_t qstat;
	qcll_rec_t   rec, head;
	logic        accept, rec_valid, fifo_pop;

	assign full   = qstat.full;
	assign accept = push && !qstat.full;

	qcll_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.char_in     (char_in),
		.end_of_line (end_of_line),
		.rec_valid   (rec_valid),
		.rec         (rec)
	);

	qcll_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (rec_valid),
		.wr_data (rec),
		.rd_en   (fifo_pop),
		.rd_data (head),
		.qstat   (qstat)
	);

	qcll_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.qstat       (qstat),
		.fifo_pop    (fifo_pop),
		.empty       (empty),
		.pop         (pop),
		.kind        (kind),
		.char_out    (char_out),
		.token_type  (token_type),
		.token_index (token_index),
		.status      (status),
		.last        (last)
	);

endmodule

### design/qcll_checker.sv
// ----------------------------------------------------------------------------
// Quoted command line lexer port checker
// Watches the top level's ports and checks result encoding and ordering rules.
// ----------------------------------------------------------------------------
`include "quoted_command_line_lexer_top_defines.svh"

module qcll_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [1:0] kind,
	input logic [7:0] char_out,
	input logic [2:0] token_type,
	input logic [7:0] token_index,
	input logic [1:0] status,
	input logic       last
);
	import qcll_pkg::*;

	logic [23:0] result_bus;

	assign result_bus = {kind, char_out, token_type, token_index, status, last};

	// A result that is not taken must stay on the ports unchanged.
	`QCLL_ASSERT_NEXT(a_result_holds, (!empty && !pop), (!empty && $stable(result_bus)), "stalled result changed")
	`QCLL_ASSERT_NOW(a_kind_legal, !empty, (kind <= KIND_STATUS), "illegal result kind")
	`QCLL_ASSERT_NOW(a_char_zero, (!empty && kind != KIND_CHAR), (char_out == 8'd0), "char on non-char result")
	`QCLL_ASSERT_NOW(a_type_only_on_end, (!empty && kind != KIND_END), (token_type == TY_ARG), "type on non-end result")
	// The line status is always the final result of its byte.
	`QCLL_ASSERT_NOW(a_status_last, (!empty && kind == KIND_STATUS), last, "status not marked last")

endmodule

bind quoted_command_line_lexer_top qcll_checker u_qcll_checker (.*);

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quoted command line lexer testbench
// Streams command lines byte by byte through the push/full channel and drains
// results through the empty/pop channel, each side with random gaps. A local
// lexer predicts the character, token end and line status results of every
// accepted byte, and each popped transaction is checked against the oldest
// prediction.
// ----------------------------------------------------------------------------
module testbench;

	import qcll_pkg::*;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] ch;
		logic [2:0] ty;
		logic [7:0] idx;
		logic [1:0] st;
		logic       last;
	} lex_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] char_in = 8'h00;
	logic       end_of_line = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic [1:0] kind;
	logic [7:0] char_out;
	logic [2:0] token_type;
	logic [7:0] token_index;
	logic [1:0] status;
	logic       last;

	quoted_command_line_lexer_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.char_in     (char_in),
		.end_of_line (end_of_line),
		.empty       (empty),
		.pop         (pop),
		.kind        (kind),
		.char_out    (char_out),
		.token_type  (token_type),
		.token_index (token_index),
		.status      (status),
		.last        (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Lexer state mirrored from the block.
	logic        in_token;
	logic        in_quote;
	logic        quote_dbl;
	logic [15:0] token_head;
	logic [1:0]  clean_len;
	int          tok_count;
	logic [2:0]  prev_type;
	logic        op_pending;
	logic        syn_err;

	lex_result_t step_res [3];
	int          step_cnt;
	lex_result_t lexer_results_due [$];

	int mismatch_count = 0;
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	int pop_hold = 0;

	function automatic void clear_line_state();
		in_token   = 1'b0;
		in_quote   = 1'b0;
		quote_dbl  = 1'b0;
		token_head = 16'h0000;
		clean_len  = 2'd0;
		tok_count  = 0;
		prev_type  = TY_ARG;
		op_pending = 1'b0;
		syn_err    = 1'b0;
	endfunction

	function automatic logic [7:0] token_slot();
		return (tok_count > 255) ? IDX_MAX : 8'(tok_count);
	endfunction

	function automatic void add_result(input logic [1:0] k, input logic [7:0] c,
			input logic [2:0] t, input logic [7:0] i, input logic [1:0] s);
		step_res[step_cnt] = '{kind: k, ch: c, ty: t, idx: i, st: s, last: 1'b0};
		step_cnt++;
	endfunction

	function automatic void close_token();
		logic [2:0] ty;
		logic       is_op;
		if (tok_count == 0 || prev_type == TY_PIPE) begin
			ty = TY_CMD;
		end else begin
			ty = TY_ARG;
		end
		// Operators are recognized on the cleaned text, so quoted ones count too.
		if (clean_len == 2'd1) begin
			case (token_head[7:0])
				CH_PIPE: ty = TY_PIPE;
				CH_GT:   ty = TY_OUT;
				CH_LT:   ty = TY_IN;
				default: ;
			endcase
		end else if (clean_len == 2'd2) begin
			if (token_head == {CH_GT, CH_GT}) begin
				ty = TY_APPEND;
			end else if (token_head == {CH_LT, CH_LT}) begin
				ty = TY_HEREDOC;
			end
		end
		is_op = (ty >= TY_PIPE);
		add_result(KIND_END, 8'h00, ty, token_slot(), ST_OK);
		if (op_pending && is_op) begin
			syn_err = 1'b1;
		end
		op_pending = is_op;
		prev_type  = ty;
		if (tok_count < MAX_TOKENS) begin
			tok_count++;
		end
		in_token = 1'b0;
	endfunction

	function automatic void lex_byte(input logic [7:0] c, input logic eol);
		logic [1:0] st;
		step_cnt = 0;
		if (!in_token && c != CH_SPACE) begin
			in_token   = 1'b1;
			token_head = 16'h0000;
			clean_len  = 2'd0;
		end
		if (in_token) begin
			if (!in_quote && c == CH_SPACE) begin
				close_token();
			end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
				if (!in_quote) begin
					in_quote  = 1'b1;
					quote_dbl = (c == CH_DQUOTE);
				end else if ((c == CH_DQUOTE) == quote_dbl) begin
					in_quote = 1'b0;
				end
			end else begin
				add_result(KIND_CHAR, c, TY_ARG, token_slot(), ST_OK);
				if (clean_len == 2'd0) begin
					token_head[7:0] = c;
				end else if (clean_len == 2'd1) begin
					token_head[15:8] = c;
				end
				if (clean_len != 2'd3) begin
					clean_len++;
				end
			end
		end
		if (eol) begin
			// An open quote swallows the token end and wins over a dangling operator.
			if (in_token && !in_quote) begin
				close_token();
			end
			if (in_quote) begin
				st = ST_UNCLOSED;
			end else if (syn_err || op_pending) begin
				st = ST_NO_ARG;
			end else begin
				st = ST_OK;
			end
			add_result(KIND_STATUS, 8'h00, TY_ARG, token_slot(), st);
			clear_line_state();
		end
		if (step_cnt > 0) begin
			step_res[step_cnt - 1].last = 1'b1;
		end
		for (int i = 0; i < step_cnt; i++) begin
			lexer_results_due.push_back(step_res[i]);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && push && !full) begin
			lex_byte(char_in, end_of_line);
		end
	end

	always @(posedge clk) begin : check_results
		lex_result_t seen;
		lex_result_t want;
		if (arst_n && pop && !empty) begin
			seen = '{kind: kind, ch: char_out, ty: token_type, idx: token_index,
				st: status, last: last};
			if (lexer_results_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("unexpected result: kind %0d char %h type %0d %s",
						seen.kind, seen.ch, seen.ty,
						$sformatf("index %0d status %0d last %0d",
							seen.idx, seen.st, seen.last));
				end
			end else begin
				want = lexer_results_due.pop_front();
				if (seen !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("mismatch at %0t: expected kind %0d char %h type %0d %s",
							$realtime, want.kind, want.ch, want.ty,
							$sformatf("index %0d status %0d last %0d",
								want.idx, want.st, want.last));
						$display("                 actual   kind %0d char %h type %0d %s",
							seen.kind, seen.ch, seen.ty,
							$sformatf("index %0d status %0d last %0d",
								seen.idx, seen.st, seen.last));
					end
				end
			end
		end
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		if ($urandom_range(0, 9) == 0) begin
			return $urandom_range(8, 30);
		end
		return $urandom_range(1, 3);
	endfunction

	always @(posedge clk) begin
		if (pop_hold > 0) begin
			pop <= 1'b0;
			pop_hold <= pop_hold - 1;
		end else if (rx_idle && $urandom_range(0, 3) == 0) begin
			pop <= 1'b0;
			pop_hold <= pick_gap() - 1;
		end else begin
			pop <= 1'b1;
		end
	end

	task automatic send_byte(input logic [7:0] c, input logic eol);
		int gap;
		push        <= 1'b1;
		char_in     <= c;
		end_of_line <= eol;
		do begin
			@(posedge clk);
		end while (full);
		gap = 0;
		if (tx_idle && $urandom_range(0, 2) == 0) begin
			gap = pick_gap();
		end
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_byte(s[i], i == s.len() - 1);
		end
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (lexer_results_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [7:0] word_char();
		case ($urandom_range(0, 9))
			7:       return 8'h30 + 8'($urandom_range(0, 9));
			8:       return 8'($urandom_range(128, 255));
			9:       return 8'($urandom_range(0, 31));
			default: return 8'h61 + 8'($urandom_range(0, 25));
		endcase
	endfunction

	task automatic test_operators();
		send_text("cat < in | grep x > out");
		send_text("sort << eof >> log");
		send_text(">>> '|' a\"|\"b");
	endtask

	task automatic test_quoting();
		send_text("echo 'a b' \"c'd\" x'y\"z'w");
		send_text("'' \"\" q");
		send_text("a\tb c");
		send_text("echo 'abc");
		send_text("| \"x");
	endtask

	task automatic test_line_status();
		send_text("ls |");
		send_text("cat > | x");
		send_text("ls >");
		send_text("ls ");
		send_text(" ");
		send_text("a");
	endtask

	task automatic test_byte_extremes();
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(CH_SPACE, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7F, 1'b1);
	endtask

	// A dense burst of one-byte tokens on one line, with no gaps on either side.
	task automatic test_token_count();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		for (int i = 0; i < 10; i++) begin
			send_byte(8'h78, 1'b0);
			send_byte(CH_SPACE, 1'b0);
		end
		send_byte(CH_PIPE, 1'b1);
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	task automatic test_drain_pause();
		send_text("make all > build");
		wait_drained();
		send_text("run | tee log");
	endtask

	task automatic test_random_lines();
		logic [7:0] line_buf [$];
		logic [7:0] q;
		int bytes_sent;
		int n_tokens;
		int len;
		bytes_sent = 0;
		while (bytes_sent < 20) begin
			line_buf = {};
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			n_tokens = $urandom_range(1, 8);
			for (int t = 0; t < n_tokens; t++) begin
				if (t > 0 || $urandom_range(0, 4) == 0) begin
					repeat ($urandom_range(1, 3)) line_buf.push_back(CH_SPACE);
				end
				case ($urandom_range(0, 9))
					0, 1, 2, 3: begin
						len = $urandom_range(1, 6);
						repeat (len) line_buf.push_back(word_char());
					end
					4, 5: begin
						case ($urandom_range(0, 4))
							0: line_buf.push_back(CH_PIPE);
							1: line_buf.push_back(CH_GT);
							2: begin
								line_buf.push_back(CH_GT);
								line_buf.push_back(CH_GT);
							end
							3: line_buf.push_back(CH_LT);
							default: begin
								line_buf.push_back(CH_LT);
								line_buf.push_back(CH_LT);
							end
						endcase
					end
					6, 7: begin
						q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
						line_buf.push_back(q);
						len = $urandom_range(0, 5);
						repeat (len) begin
							case ($urandom_range(0, 3))
								0: line_buf.push_back(CH_SPACE);
								1: line_buf.push_back(q == CH_SQUOTE ? CH_DQUOTE : CH_SQUOTE);
								default: line_buf.push_back(word_char());
							endcase
						end
						line_buf.push_back(q);
						if ($urandom_range(0, 1) == 0) begin
							line_buf.push_back(word_char());
						end
					end
					8: begin
						line_buf.push_back(CH_SQUOTE);
						line_buf.push_back(CH_SQUOTE);
					end
					default: begin
						len = $urandom_range(1, 5);
						repeat (len) line_buf.push_back(8'($urandom_range(0, 255)));
					end
				endcase
			end
			case ($urandom_range(0, 9))
				0: begin
					line_buf.push_back($urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE);
					line_buf.push_back(word_char());
				end
				1: line_buf.push_back(CH_SPACE);
				default: ;
			endcase
			for (int i = 0; i < line_buf.size(); i++) begin
				send_byte(line_buf[i], i == line_buf.size() - 1);
			end
			bytes_sent += line_buf.size();
		end
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	initial begin
		clear_line_state();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_operators();
		test_quoting();
		test_line_status();
		test_byte_extremes();
		test_drain_pause();
		test_token_count();
		test_random_lines();
		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && lexer_results_due.size() == 0) begin
			$display("quoted_command_line_lexer_top verification clean");
		end else begin
			$display("quoted_command_line_lexer_top verification failed");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("quoted_command_line_lexer_top verification failed");
		$finish;
	end

endmodule
